// ===== rtl/snfcs_pkg.sv =====
// Shared types, codes and constants of the SPI NOR flash command sequencer.
package snfcs_pkg;

	localparam int REQ_W      = 3;
	localparam int ADDR_W     = 24;
	localparam int LEN_W      = 24;
	localparam int STAT_W     = 8;
	localparam int OPC_W      = 8;
	localparam int OPST_W     = 3;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_PAGE_BYTES   = 256;
	localparam int DEF_SECTOR_BYTES = 4096;
	localparam int DEF_DEVICE_BYTES = 8388608;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5000;

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_READY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT = 1'b1;

	localparam logic [OPC_W-1:0] OPC_WREN    = 8'h06;
	localparam logic [OPC_W-1:0] OPC_STATUS  = 8'h05;
	localparam logic [OPC_W-1:0] OPC_READ    = 8'h03;
	localparam logic [OPC_W-1:0] OPC_PROGRAM = 8'h02;
	localparam logic [OPC_W-1:0] OPC_ERASE   = 8'h20;

	localparam int STATUS_BUSY_BIT = 0;
	localparam int STATUS_WEL_BIT  = 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ    = 3'd0,
		REQ_PROGRAM = 3'd1,
		REQ_ERASE   = 3'd2,
		REQ_SYNC    = 3'd3,
		REQ_STATUS  = 3'd4,
		REQ_TICK    = 3'd5
	} req_type_t;

	typedef enum logic [OPST_W-1:0] {
		OPST_RUN      = 3'd0,
		OPST_OK       = 3'd1,
		OPST_REJECT   = 3'd2,
		OPST_WEL_FAIL = 3'd3,
		OPST_TIMEOUT  = 3'd4
	} op_status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WEL,
		PH_BUSY,
		PH_TICK
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PROGRAM,
		KIND_ERASE,
		KIND_SYNC
	} kind_t;

	typedef struct packed {
		logic              has_frame;
		logic [OPC_W-1:0]  opcode;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  data_length;
		op_status_t        op_status;
	} res_t;

	// one queue entry: a first result, optionally followed by a status read
	typedef struct packed {
		res_t head;
		logic pair;
	} q_entry_t;

endpackage

// ===== rtl/snfcs_if.sv =====
// Valid/ready channel interfaces for request items and result items.
interface snfcs_req_if;
	logic                           valid;
	logic                           ready;
	logic [snfcs_pkg::REQ_W-1:0]    req_type;
	logic [snfcs_pkg::ADDR_W-1:0]   address;
	logic [snfcs_pkg::LEN_W-1:0]    length;
	logic [snfcs_pkg::STAT_W-1:0]   status_byte;

	modport source (output valid, req_type, address, length, status_byte, input ready);
	modport sink   (input valid, req_type, address, length, status_byte, output ready);
endinterface

interface snfcs_res_if;
	logic                           valid;
	logic                           ready;
	logic                           has_frame;
	logic [snfcs_pkg::OPC_W-1:0]    frame_opcode;
	logic [snfcs_pkg::ADDR_W-1:0]   frame_address;
	logic [snfcs_pkg::LEN_W-1:0]    frame_data_length;
	logic [snfcs_pkg::OPST_W-1:0]   op_status;
	logic                           last;

	modport source (output valid, has_frame, frame_opcode, frame_address, frame_data_length,
		op_status, last, input ready);
	modport sink   (input valid, has_frame, frame_opcode, frame_address, frame_data_length,
		op_status, last, output ready);
endinterface

// ===== rtl/spi_nor_flash_command_sequencer_core.sv =====
// Top level of the SPI NOR flash command sequencer.
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    req_type, address, length, status_byte
//  res      out  valid / ready    has_frame, frame_opcode, frame_address,
//                                 frame_data_length, op_status, last
//  cfg      in   cfg_we           cfg_index, cfg_wdata
//
// An item is taken on a valid/ready handshake; its results leave the result queue one per cycle
// while res is not stalled, so an item that yields two results gives two result items.
// The first result can appear the cycle after the item is accepted.
// The front end keeps taking items until the four-entry queue fills.
// arst_n clears all control state at once; there is no clearing pass.
// A stall on res does not hold req until the queue is full.
module spi_nor_flash_command_sequencer_core #(
	parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
	parameter int SECTOR_BYTES = snfcs_pkg::DEF_SECTOR_BYTES,
	parameter int DEVICE_BYTES = snfcs_pkg::DEF_DEVICE_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [snfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snfcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	snfcs_req_if.sink                        req,
	snfcs_res_if.source                      res
);
	import snfcs_pkg::*;

	logic     push;
	q_entry_t push_entry;
	logic     q_full;

	snfcs_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES),
		.DEVICE_BYTES (DEVICE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	snfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.res        (res)
	);

endmodule

// ===== rtl/snfcs_front.sv =====
// Front end: accepts items, keeps the operation state, queues the results.
module snfcs_front #(
	parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
	parameter int SECTOR_BYTES = snfcs_pkg::DEF_SECTOR_BYTES,
	parameter int DEVICE_BYTES = snfcs_pkg::DEF_DEVICE_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [snfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snfcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	snfcs_req_if.sink                        req,
	output logic                             push,
	output snfcs_pkg::q_entry_t              push_entry,
	input  logic                             q_full
);
	import snfcs_pkg::*;

	localparam int PG_W    = $clog2(PAGE_BYTES);
	localparam int CHUNK_W = PG_W + 1;
	localparam logic [ADDR_W:0]   DEV_SPAN    = (ADDR_W+1)'(DEVICE_BYTES);
	localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'(SECTOR_BYTES - 1);
	localparam logic [ADDR_W-1:0] SECTOR_STEP = ADDR_W'(SECTOR_BYTES);

	logic                dev_ready_q;
	logic [TICK_W-1:0]   timeout_q;
	phase_t              phase_q, phase_d;
	kind_t               kind_q, kind_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [LEN_W-1:0]    rem_q, rem_d;
	logic [CHUNK_W-1:0]  chunk_q, chunk_d;
	logic [TICK_W-1:0]   ticks_q, ticks_d;

	logic                acc;
	logic                range_bad;
	logic                align_bad;
	logic                req_ok;
	logic [ADDR_W-1:0]   step;
	logic [ADDR_W-1:0]   step_addr;
	logic [LEN_W-1:0]    step_rem;
	logic                rem_zero;
	logic                timed_out;
	logic [ADDR_W-1:0]   ws_addr;
	logic [LEN_W-1:0]    ws_rem;
	logic [CHUNK_W-1:0]  chunk_new;
	logic                sb_busy;
	logic                sb_wel;

	// bytes up to the next page boundary, capped by what is left
	function automatic logic [CHUNK_W-1:0] chunk_calc(input logic [ADDR_W-1:0] a,
		input logic [LEN_W-1:0] r);
		logic [CHUNK_W-1:0] room;
		room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(a[PG_W-1:0]);
		if (r < LEN_W'(room)) begin
			chunk_calc = r[CHUNK_W-1:0];
		end else begin
			chunk_calc = room;
		end
	endfunction

	assign req.ready = !q_full;
	assign acc       = req.valid && req.ready;
	assign sb_busy   = req.status_byte[STATUS_BUSY_BIT];
	assign sb_wel    = req.status_byte[STATUS_WEL_BIT];

	// request classification and step arithmetic
	always_comb begin
		range_bad = (req.req_type != REQ_SYNC) && ((req.length == '0) ||
			({1'b0, req.address} > DEV_SPAN) ||
			({1'b0, req.length} > (DEV_SPAN - {1'b0, req.address})));
		align_bad = (req.req_type == REQ_ERASE) &&
			(((req.address | req.length) & SECTOR_MASK) != '0);
		req_ok = (phase_q == PH_IDLE) && dev_ready_q && !range_bad && !align_bad;

		step      = (kind_q == KIND_PROGRAM) ? ADDR_W'(chunk_q) : SECTOR_STEP;
		step_rem  = (step >= rem_q) ? '0 : rem_q - step;
		step_addr = addr_q + step;
		rem_zero  = (step_rem == '0);
		timed_out = (ticks_q >= timeout_q);

		ws_addr   = (phase_q == PH_IDLE) ? req.address : step_addr;
		ws_rem    = (phase_q == PH_IDLE) ? req.length : step_rem;
		chunk_new = chunk_calc(ws_addr, ws_rem);
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		addr_d  = addr_q;
		rem_d   = rem_q;
		chunk_d = chunk_q;
		ticks_d = ticks_q;
		if (acc) begin
			case (req.req_type)
				REQ_READ, REQ_PROGRAM, REQ_ERASE, REQ_SYNC: begin
					if (req_ok && req.req_type != REQ_READ) begin
						addr_d  = req.address;
						rem_d   = req.length;
						ticks_d = '0;
						if (req.req_type == REQ_SYNC) begin
							kind_d  = KIND_SYNC;
							phase_d = PH_BUSY;
						end else begin
							kind_d  = (req.req_type == REQ_PROGRAM) ? KIND_PROGRAM : KIND_ERASE;
							phase_d = PH_WEL;
							if (req.req_type == REQ_PROGRAM) begin
								chunk_d = chunk_new;
							end
						end
					end
				end
				REQ_STATUS: begin
					case (phase_q)
						PH_WEL: begin
							if (!sb_wel) begin
								phase_d = PH_IDLE;
							end else begin
								ticks_d = '0;
								phase_d = PH_BUSY;
							end
						end
						PH_BUSY: begin
							if (sb_busy) begin
								phase_d = timed_out ? PH_IDLE : PH_TICK;
							end else if (kind_q == KIND_SYNC) begin
								phase_d = PH_IDLE;
							end else begin
								rem_d  = step_rem;
								addr_d = step_addr;
								if (rem_zero) begin
									phase_d = PH_IDLE;
								end else begin
									phase_d = PH_WEL;
									if (kind_q == KIND_PROGRAM) begin
										chunk_d = chunk_new;
									end
								end
							end
						end
						default: ;
					endcase
				end
				REQ_TICK: begin
					if (phase_q == PH_BUSY || phase_q == PH_TICK) begin
						if (ticks_q != '1) begin
							ticks_d = ticks_q + 1'b1;
						end
					end
					if (phase_q == PH_TICK) begin
						phase_d = PH_BUSY;
					end
				end
				default: ;
			endcase
		end
	end

	// results pushed to the queue
	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		if (acc) begin
			case (req.req_type)
				REQ_READ, REQ_PROGRAM, REQ_ERASE, REQ_SYNC: begin
					push = 1'b1;
					if (!req_ok) begin
						push_entry.head.op_status = OPST_REJECT;
					end else if (req.req_type == REQ_READ) begin
						push_entry.head.has_frame   = 1'b1;
						push_entry.head.opcode      = OPC_READ;
						push_entry.head.address     = req.address;
						push_entry.head.data_length = req.length;
						push_entry.head.op_status   = OPST_OK;
					end else if (req.req_type == REQ_SYNC) begin
						push_entry.head.has_frame   = 1'b1;
						push_entry.head.opcode      = OPC_STATUS;
						push_entry.head.data_length = LEN_W'(1);
					end else begin
						push_entry.head.has_frame = 1'b1;
						push_entry.head.opcode    = OPC_WREN;
						push_entry.pair           = 1'b1;
					end
				end
				REQ_STATUS: begin
					case (phase_q)
						PH_WEL: begin
							push = 1'b1;
							if (!sb_wel) begin
								push_entry.head.op_status = OPST_WEL_FAIL;
							end else begin
								push_entry.head.has_frame = 1'b1;
								push_entry.head.address   = addr_q;
								push_entry.pair           = 1'b1;
								if (kind_q == KIND_PROGRAM) begin
									push_entry.head.opcode      = OPC_PROGRAM;
									push_entry.head.data_length = LEN_W'(chunk_q);
								end else begin
									push_entry.head.opcode = OPC_ERASE;
								end
							end
						end
						PH_BUSY: begin
							if (sb_busy) begin
								if (timed_out) begin
									push                      = 1'b1;
									push_entry.head.op_status = OPST_TIMEOUT;
								end
							end else if (kind_q == KIND_SYNC || rem_zero) begin
								push                      = 1'b1;
								push_entry.head.op_status = OPST_OK;
							end else begin
								push                      = 1'b1;
								push_entry.head.has_frame = 1'b1;
								push_entry.head.opcode    = OPC_WREN;
								push_entry.pair           = 1'b1;
							end
						end
						default: ;
					endcase
				end
				REQ_TICK: begin
					if (phase_q == PH_TICK) begin
						push                        = 1'b1;
						push_entry.head.has_frame   = 1'b1;
						push_entry.head.opcode      = OPC_STATUS;
						push_entry.head.data_length = LEN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_ready_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			phase_q     <= PH_IDLE;
			kind_q      <= KIND_NONE;
			addr_q      <= '0;
			rem_q       <= '0;
			chunk_q     <= '0;
			ticks_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEVICE_READY: dev_ready_q <= cfg_wdata[0];
					CFG_BUSY_TIMEOUT: timeout_q   <= cfg_wdata[TICK_W-1:0];
					default: ;
				endcase
			end
			phase_q <= phase_d;
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
			chunk_q <= chunk_d;
			ticks_q <= ticks_d;
		end
	end

endmodule

// ===== rtl/snfcs_back.sv =====
// Back end: result queue and serializer that issues one result item per cycle while res is ready.
module snfcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  snfcs_pkg::q_entry_t push_entry,
	output logic                q_full,
	snfcs_res_if.source         res
);
	import snfcs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] FULL_COUNT = (PTR_W+1)'(QUEUE_DEPTH);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic              second_q;

	q_entry_t          head;
	logic              take;
	logic              pop;

	assign head   = mem_q[rd_ptr_q];
	assign q_full = (count_q == FULL_COUNT);
	assign take   = res.valid && res.ready;
	// a paired entry leaves only after its trailing status read
	assign pop    = take && (second_q || !head.pair);

	always_comb begin
		res.valid = (count_q != '0);
		if (second_q) begin
			res.has_frame         = 1'b1;
			res.frame_opcode      = OPC_STATUS;
			res.frame_address     = '0;
			res.frame_data_length = LEN_W'(1);
			res.op_status         = OPST_RUN;
			res.last              = 1'b1;
		end else begin
			res.has_frame         = head.head.has_frame;
			res.frame_opcode      = head.head.opcode;
			res.frame_address     = head.head.address;
			res.frame_data_length = head.head.data_length;
			res.op_status         = head.head.op_status;
			res.last              = !head.pair;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			second_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (take) begin
				second_q <= !pop;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/snfcs_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module snfcs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic                             has_frame,
	input logic [snfcs_pkg::OPC_W-1:0]      frame_opcode,
	input logic [snfcs_pkg::ADDR_W-1:0]     frame_address,
	input logic [snfcs_pkg::LEN_W-1:0]      frame_data_length,
	input logic [snfcs_pkg::OPST_W-1:0]     op_status,
	input logic                             last
);
	import snfcs_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(frame_opcode) &&
		$stable(frame_address) && $stable(frame_data_length) && $stable(last))
		else $error("result changed while stalled");

	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_frame |-> frame_opcode == '0 && frame_address == '0 &&
		frame_data_length == '0 && last)
		else $error("frameless result carries frame fields");

	a_status_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_frame && frame_opcode == OPC_STATUS |->
		frame_data_length == LEN_W'(1) && frame_address == '0 && last)
		else $error("malformed status read");

	a_wren_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_frame && frame_opcode == OPC_WREN |->
		!last && op_status == OPST_RUN)
		else $error("write enable not followed by status read");

	a_fail_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (op_status == OPST_REJECT || op_status == OPST_WEL_FAIL ||
		op_status == OPST_TIMEOUT) |-> !has_frame && last)
		else $error("failure result carries a frame");

endmodule

bind spi_nor_flash_command_sequencer_core snfcs_checker u_snfcs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.has_frame         (res.has_frame),
	.frame_opcode      (res.frame_opcode),
	.frame_address     (res.frame_address),
	.frame_data_length (res.frame_data_length),
	.op_status         (res.op_status),
	.last              (res.last)
);

// ===== bench/spi_nor_flash_command_sequencer_core_test.sv =====
// Self-checking bench for the SPI NOR flash command sequencer core.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_core_test;
	import snfcs_pkg::*;

	localparam int unsigned PAGE   = DEF_PAGE_BYTES;
	localparam int unsigned SECTOR = DEF_SECTOR_BYTES;
	localparam int unsigned DEVICE = DEF_DEVICE_BYTES;

	typedef struct {
		logic              has_frame;
		logic [OPC_W-1:0]  opcode;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  data_length;
		op_status_t        op_status;
		logic              last;
	} frame_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	snfcs_req_if req();
	snfcs_res_if res();

	spi_nor_flash_command_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res)
	);

	// expected frames, oldest first
	frame_t frames_due[$];
	int     mismatches = 0;
	int     sender_gap_pct = 0;
	int     sink_stall_pct = 0;
	int     stall_left = 0;

	// sequencer mirror
	logic              dev_ready = 1'b0;
	logic [TICK_W-1:0] busy_limit = TIMEOUT_RESET;
	phase_t            seq_phase = PH_IDLE;
	kind_t             seq_kind = KIND_NONE;
	logic [ADDR_W-1:0] seq_addr = '0;
	logic [LEN_W-1:0]  seq_left = '0;
	logic [12:0]       seq_chunk = '0;
	logic [TICK_W-1:0] seq_ticks = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("spi_nor_flash_command_sequencer_core verification failed");
		$finish;
	end

	function automatic void queue_frame(logic has, logic [OPC_W-1:0] opc, logic [ADDR_W-1:0] addr,
		logic [LEN_W-1:0] len, op_status_t st, logic fin);
		frame_t f;
		f.has_frame   = has;
		f.opcode      = opc;
		f.address     = addr;
		f.data_length = len;
		f.op_status   = st;
		f.last        = fin;
		frames_due.push_back(f);
	endfunction

	function automatic void close_op(op_status_t st);
		seq_phase = PH_IDLE;
		queue_frame(1'b0, '0, '0, '0, st, 1'b1);
	endfunction

	// write enable, then a status read that must show the latch
	function automatic void begin_write_step();
		int unsigned chunk;
		if (seq_kind == KIND_PROGRAM) begin
			chunk = PAGE - (seq_addr & (PAGE - 1));
			if (chunk > seq_left)
				chunk = 32'(seq_left);
			seq_chunk = chunk[12:0];
		end
		seq_phase = PH_WEL;
		queue_frame(1'b1, OPC_WREN, '0, '0, OPST_RUN, 1'b0);
		queue_frame(1'b1, OPC_STATUS, '0, 24'd1, OPST_RUN, 1'b1);
	endfunction

	function automatic void advance_sequencer(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
		logic [LEN_W-1:0] len, logic [STAT_W-1:0] sb);
		logic        ok;
		int unsigned advance;
		if (kind <= REQ_SYNC) begin
			ok = (seq_phase == PH_IDLE) && dev_ready;
			if (kind != REQ_SYNC && (len == 0 || addr > DEVICE || len > DEVICE - addr))
				ok = 1'b0;
			if (kind == REQ_ERASE && ((addr | len) & (SECTOR - 1)) != 0)
				ok = 1'b0;
			if (!ok) begin
				queue_frame(1'b0, '0, '0, '0, OPST_REJECT, 1'b1);
			end else if (kind == REQ_READ) begin
				queue_frame(1'b1, OPC_READ, addr, len, OPST_OK, 1'b1);
			end else begin
				seq_addr  = addr;
				seq_left  = len;
				seq_ticks = '0;
				if (kind == REQ_SYNC) begin
					seq_kind  = KIND_SYNC;
					seq_phase = PH_BUSY;
					queue_frame(1'b1, OPC_STATUS, '0, 24'd1, OPST_RUN, 1'b1);
				end else begin
					seq_kind = (kind == REQ_PROGRAM) ? KIND_PROGRAM : KIND_ERASE;
					begin_write_step();
				end
			end
		end else if (kind == REQ_STATUS) begin
			case (seq_phase)
				PH_WEL: begin
					if (!sb[STATUS_WEL_BIT]) begin
						close_op(OPST_WEL_FAIL);
					end else begin
						if (seq_kind == KIND_PROGRAM)
							queue_frame(1'b1, OPC_PROGRAM, seq_addr, 24'(seq_chunk), OPST_RUN, 1'b0);
						else
							queue_frame(1'b1, OPC_ERASE, seq_addr, '0, OPST_RUN, 1'b0);
						queue_frame(1'b1, OPC_STATUS, '0, 24'd1, OPST_RUN, 1'b1);
						seq_ticks = '0;
						seq_phase = PH_BUSY;
					end
				end
				PH_BUSY: begin
					if (sb[STATUS_BUSY_BIT]) begin
						if (seq_ticks >= busy_limit)
							close_op(OPST_TIMEOUT);
						else
							seq_phase = PH_TICK;
					end else if (seq_kind == KIND_SYNC) begin
						close_op(OPST_OK);
					end else begin
						advance = (seq_kind == KIND_PROGRAM) ? seq_chunk : SECTOR;
						if (advance >= seq_left)
							seq_left = '0;
						else
							seq_left = 24'(seq_left - advance);
						seq_addr = 24'(seq_addr + advance);
						if (seq_left == 0)
							close_op(OPST_OK);
						else
							begin_write_step();
					end
				end
				default: ;
			endcase
		end else if (kind == REQ_TICK) begin
			if ((seq_phase == PH_BUSY || seq_phase == PH_TICK) && seq_ticks != 16'hFFFF)
				seq_ticks++;
			if (seq_phase == PH_TICK) begin
				seq_phase = PH_BUSY;
				queue_frame(1'b1, OPC_STATUS, '0, 24'd1, OPST_RUN, 1'b1);
			end
		end
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
	endtask

	// values are stable from the falling edge up to the accepting rising edge
	always @(negedge clk) begin
		frame_t want;
		if (arst_n && res.valid && res.ready) begin
			if (frames_due.size() == 0) begin
				flag_mismatch("unexpected result, opcode", '0, res.frame_opcode);
			end else begin
				want = frames_due.pop_front();
				if (res.has_frame !== want.has_frame)
					flag_mismatch("has_frame", want.has_frame, res.has_frame);
				if (res.frame_opcode !== want.opcode)
					flag_mismatch("frame_opcode", want.opcode, res.frame_opcode);
				if (res.frame_address !== want.address)
					flag_mismatch("frame_address", want.address, res.frame_address);
				if (res.frame_data_length !== want.data_length)
					flag_mismatch("frame_data_length", want.data_length, res.frame_data_length);
				if (res.op_status !== want.op_status)
					flag_mismatch("op_status", want.op_status, res.op_status);
				if (res.last !== want.last)
					flag_mismatch("last", want.last, res.last);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// valid stays high between back-to-back items; it drops only in a gap or in wait_drained
	task automatic send_item(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
		logic [LEN_W-1:0] len, logic [STAT_W-1:0] sb);
		logic took;
		while ($urandom_range(99) < sender_gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.req_type    <= kind;
		req.address     <= addr;
		req.length      <= len;
		req.status_byte <= sb;
		do begin
			@(negedge clk);
			took = req.ready;
			@(posedge clk);
		end while (!took);
		advance_sequencer(kind, addr, len, sb);
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEVICE_READY)
			dev_ready = value[0];
		else
			busy_limit = value;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		req.valid <= 1'b0;
		guard = 0;
		while (frames_due.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);
	endtask

	// replies that walk a running operation to a clean end
	task automatic finish_running();
		while (seq_phase != PH_IDLE) begin
			case (seq_phase)
				PH_WEL:  send_item(REQ_STATUS, ADDR_W'($urandom), LEN_W'($urandom), 8'h02);
				PH_BUSY: send_item(REQ_STATUS, ADDR_W'($urandom), LEN_W'($urandom), 8'h00);
				default: send_item(REQ_TICK, ADDR_W'($urandom), LEN_W'($urandom),
					STAT_W'($urandom));
			endcase
		end
	endtask

	task automatic random_item();
		logic [REQ_W-1:0]  kind;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] sb;
		int                pick;
		int unsigned       span;
		kind = REQ_W'($urandom_range(0, 7));
		addr = ADDR_W'($urandom);
		len  = LEN_W'($urandom);
		sb   = STAT_W'($urandom);
		pick = $urandom_range(99);
		case (seq_phase)
			PH_IDLE: begin
				if (pick < 20) begin
					kind = REQ_READ;
					len  = 24'($urandom_range(1, DEVICE));
					addr = 24'($urandom_range(0, DEVICE - len));
				end else if (pick < 50) begin
					kind = REQ_PROGRAM;
					len  = (pick < 45) ? 24'($urandom_range(1, 600)) : 24'($urandom_range(1, 4096));
					addr = (pick % 7 == 0) ? 24'(DEVICE - len) : 24'($urandom_range(0, DEVICE - len));
				end else if (pick < 68) begin
					kind = REQ_ERASE;
					span = $urandom_range(1, 3);
					addr = 24'(SECTOR * $urandom_range(0, DEVICE / SECTOR - span));
					len  = 24'(SECTOR * span);
				end else if (pick < 80) begin
					kind = REQ_SYNC;
				end
			end
			PH_WEL: begin
				if (pick < 88)
					kind = REQ_STATUS;
				if (pick < 80)
					sb[STATUS_WEL_BIT] = 1'b1;
				else if (pick < 88)
					sb[STATUS_WEL_BIT] = 1'b0;
			end
			PH_BUSY: begin
				if (pick < 75)
					kind = REQ_STATUS;
				if (pick < 45)
					sb[STATUS_BUSY_BIT] = 1'b0;
				else if (pick < 75)
					sb[STATUS_BUSY_BIT] = 1'b1;
				else if (pick < 90)
					kind = REQ_TICK;
			end
			default: begin
				if (pick < 80)
					kind = REQ_TICK;
			end
		endcase
		send_item(kind, addr, len, sb);
	endtask

	task automatic test_not_ready();
		send_item(REQ_READ, 24'd0, 24'd1, 8'h00);
		send_item(REQ_PROGRAM, 24'd0, 24'd256, 8'h00);
		send_item(REQ_SYNC, 24'd0, 24'd0, 8'h00);
		send_item(REQ_ERASE, 24'd0, 24'(SECTOR), 8'h00);
		// idle-phase replies and unused request codes produce nothing
		send_item(REQ_TICK, ADDR_W'($urandom), LEN_W'($urandom), STAT_W'($urandom));
		send_item(REQ_STATUS, ADDR_W'($urandom), LEN_W'($urandom), 8'hFF);
		send_item(3'd6, ADDR_W'($urandom), LEN_W'($urandom), STAT_W'($urandom));
		send_item(3'd7, ADDR_W'($urandom), LEN_W'($urandom), STAT_W'($urandom));
		wait_drained();
	endtask

	task automatic test_reads();
		set_register(CFG_DEVICE_READY, 16'd1);
		send_item(REQ_READ, 24'd0, 24'd1, 8'h00);
		send_item(REQ_READ, 24'd0, 24'(DEVICE), 8'h00);
		send_item(REQ_READ, 24'(DEVICE - 1), 24'd1, 8'h00);
		send_item(REQ_READ, 24'(DEVICE), 24'd1, 8'h00);
		send_item(REQ_READ, 24'hFFFFFF, 24'hFFFFFF, 8'h00);
		send_item(REQ_READ, 24'd0, 24'd0, 8'h00);
		send_item(REQ_READ, 24'd1, 24'(DEVICE), 8'h00);
		wait_drained();
	endtask

	task automatic test_program_pages();
		set_register(CFG_BUSY_TIMEOUT, 16'd3);
		// crosses one page boundary: two chunks of 16 bytes
		send_item(REQ_PROGRAM, 24'h0000F0, 24'h000020, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h02);
		send_item(REQ_READ, 24'd0, 24'd16, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h03);
		send_item(REQ_TICK, 24'd0, 24'd0, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h02);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h00);
		wait_drained();
	endtask

	task automatic test_erase_faults();
		send_item(REQ_ERASE, 24'h000800, 24'(SECTOR), 8'h00);
		send_item(REQ_ERASE, 24'd0, 24'h000800, 8'h00);
		send_item(REQ_ERASE, 24'(DEVICE - SECTOR), 24'(SECTOR), 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h02);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h00);
		// latch not set after write enable
		send_item(REQ_PROGRAM, 24'd0, 24'd1, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'hFD);
		wait_drained();
	endtask

	task automatic test_busy_timeout();
		set_register(CFG_BUSY_TIMEOUT, 16'd0);
		send_item(REQ_SYNC, 24'd0, 24'd0, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h01);
		wait_drained();
		set_register(CFG_BUSY_TIMEOUT, 16'd1);
		send_item(REQ_SYNC, 24'hFFFFFF, 24'hFFFFFF, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h01);
		send_item(REQ_TICK, 24'd0, 24'd0, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h01);
		wait_drained();
	endtask

	// ticks seen while a busy reply is awaited still count toward the limit
	task automatic test_tick_count();
		set_register(CFG_BUSY_TIMEOUT, 16'd40);
		send_item(REQ_SYNC, 24'd0, 24'd0, 8'h00);
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h01);
		repeat (30) send_item(REQ_TICK, ADDR_W'($urandom), LEN_W'($urandom),
			STAT_W'($urandom));
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h01);
		repeat (12) send_item(REQ_TICK, ADDR_W'($urandom), LEN_W'($urandom),
			STAT_W'($urandom));
		send_item(REQ_STATUS, 24'd0, 24'd0, 8'h01);
		finish_running();
		wait_drained();
	endtask

	task automatic test_backpressure();
		sender_gap_pct = 0;
		sink_stall_pct = 0;
		stall_left = 400;
		repeat (16) send_item(REQ_READ, 24'($urandom_range(0, DEVICE - 64)),
			24'($urandom_range(1, 64)), STAT_W'($urandom));
		wait_drained();
	endtask

	task automatic test_random(int count, int gap_pct, int stall_pct,
		logic [CFG_DATA_W-1:0] limit);
		set_register(CFG_BUSY_TIMEOUT, limit);
		sender_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		repeat (count) random_item();
		finish_running();
		wait_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		req.valid       = 1'b0;
		req.req_type    = '0;
		req.address     = '0;
		req.length      = '0;
		req.status_byte = '0;
		res.ready       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sink_stall_pct = 30;
		test_not_ready();
		test_reads();
		test_program_pages();
		test_erase_faults();
		test_busy_timeout();
		test_tick_count();
		test_backpressure();
		test_random(620, 37, 83, 16'd3);
		test_random(620, 83, 37, 16'hFFFF);
		test_random(620, 0, 0, 16'd1);

		wait_drained();
		if (frames_due.size() != 0) begin
			$display("%0d expected results never arrived", frames_due.size());
			mismatches += frames_due.size();
		end
		if (mismatches == 0)
			$display("spi_nor_flash_command_sequencer_core verification clean");
		else
			$display("spi_nor_flash_command_sequencer_core verification failed");
		$finish;
	end

endmodule
